// ===== src/assert_macros.svh =====
// Assertion macros shared by the RTL.
// Concurrent checks compile away when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Clocked check, disabled while the active-low reset is asserted.
`define DIR_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
    else $error("dir assertion failed");
// Clocked implication check, disabled during reset.
`define DIR_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("dir assertion failed");
`else
`define DIR_ASSERT(lbl, clk, rstn, prop)
`define DIR_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`endif
`endif

// ===== src/dir_pkg.sv =====
// Package for the disjoint interval reserve block: default sizes.
// No dependencies.
`default_nettype none
package dir_pkg;
  localparam int unsigned DEF_TABLE_DEPTH = 64;
  localparam int unsigned DEF_COORD_BITS  = 32;
endpackage
`default_nettype wire

// ===== src/dir_range_mem.sv =====
// Range table storage: one write port, one read port, registered read data.
// Uses dir_pkg for its default sizes; sized by the top level.
`default_nettype none
module dir_range_mem #(
  parameter int unsigned DEPTH = dir_pkg::DEF_TABLE_DEPTH,
  parameter int unsigned AW    = 6,
  parameter int unsigned DW    = 2 * dir_pkg::DEF_COORD_BITS
) (
  input  wire logic          clk_i,
  input  wire logic          wr_en_i,
  input  wire logic [AW-1:0] wr_addr_i,
  input  wire logic [DW-1:0] wr_data_i,
  input  wire logic          rd_en_i,
  input  wire logic [AW-1:0] rd_addr_i,
  output      logic [DW-1:0] rd_data_o
);
  logic [DW-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_o <= mem_q[rd_addr_i];
    end
  end
endmodule
`default_nettype wire

// ===== src/disjoint_interval_reserve.sv =====
// Disjoint interval reserve: top level, control sequencer and result register.
// Depends on dir_pkg, dir_range_mem and assert_macros.svh.
//
// Usage:
//  - Slave channel s_axis_*: one item per closed range, start in the low
//    COORD_BITS bits of tdata, end in the next COORD_BITS bits.
//  - Master channel m_axis_*: one result item per request: accepted flag,
//    table_full flag and the running best (largest end - start + 2, 1 at start).
//  - A request is compared with every stored range, one memory read per
//    cycle. It is stored only if it shares no coordinate with any of them.
//  - Sequence: after acceptance the sequencer reads the N ranges stored so far
//    (none while the table is empty), drains the last compare, ends the scan
//    and then decides and writes, reading through the single read port of
//    the range memory. tready comes back in the cycle after the decide step,
//    so a new request is taken only once the previous one has been decided.
//  - Only one request is in flight; tready is high while the sequencer idles.
//    A new request is taken while the previous result still waits in the
//    output register.
//  - Receiver stall: the sequencer holds in its decide step until the output
//    register is free; nothing is lost or repeated.
//  - Reset (rst_ni low, async): table empty, best = 1, no result pending.
//    The memory is not cleared; only entries below the fill count are read.
`default_nettype none
module disjoint_interval_reserve #(
  parameter int unsigned TABLE_DEPTH = dir_pkg::DEF_TABLE_DEPTH,
  parameter int unsigned COORD_BITS  = dir_pkg::DEF_COORD_BITS,
  localparam int unsigned IN_W  = ((2 * COORD_BITS) + 7) / 8 * 8,
  localparam int unsigned OUT_W = ((COORD_BITS + 3) + 7) / 8 * 8
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             s_axis_tvalid_i,
  output      logic             s_axis_tready_o,
  // fields from bit 0: range_start, range_end, zero pad
  input  wire logic [IN_W-1:0]  s_axis_tdata_i,
  output      logic             m_axis_tvalid_o,
  input  wire logic             m_axis_tready_i,
  // fields from bit 0: accepted, table_full, best_value, zero pad
  output      logic [OUT_W-1:0] m_axis_tdata_o
);
  `include "assert_macros.svh"

  localparam int unsigned AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned BW = COORD_BITS + 1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DONE
  } state_e;

  state_e                state_q;
  logic [COORD_BITS-1:0] start_q;   // request under test
  logic [COORD_BITS-1:0] end_q;
  logic [BW-1:0]         span_q;    // end - start + 2
  logic                  bad_q;     // inverted range
  logic [CW-1:0]         idx_q;     // next entry to read
  logic                  cmp_q;     // read data valid this cycle
  logic                  hit_q;     // overlap seen so far
  logic [CW-1:0]         count_q;
  logic [BW-1:0]         best_q;
  logic                  ovalid_q;
  logic                  oacc_q;
  logic                  ofull_q;
  logic [BW-1:0]         obest_q;

  logic [COORD_BITS-1:0] in_start;
  logic [COORD_BITS-1:0] in_end;
  logic                  issue;
  logic [2*COORD_BITS-1:0] rd_data;
  logic [COORD_BITS-1:0] rd_start;
  logic [COORD_BITS-1:0] rd_end;
  logic                  hit_now;
  logic                  out_free;
  logic                  clean;
  logic                  is_full;
  logic                  can_store;
  logic                  wr_en;
  logic                  done_fire;
  logic [BW-1:0]         best_d;

  assign in_start = s_axis_tdata_i[COORD_BITS-1:0];
  assign in_end   = s_axis_tdata_i[2*COORD_BITS-1:COORD_BITS];

  // one read per cycle over the filled part of the table
  assign issue    = (state_q == ST_SCAN) && (idx_q < count_q);
  assign rd_start = rd_data[COORD_BITS-1:0];
  assign rd_end   = rd_data[2*COORD_BITS-1:COORD_BITS];
  // closed ranges: touching endpoints count as overlap
  assign hit_now  = cmp_q && (start_q <= rd_end) && (end_q >= rd_start);

  assign out_free  = !ovalid_q || m_axis_tready_i;
  assign clean     = !bad_q && !hit_q;
  assign is_full   = (count_q == CW'(TABLE_DEPTH));
  assign can_store = clean && !is_full;
  assign done_fire = (state_q == ST_DONE) && out_free;
  assign wr_en     = done_fire && can_store;
  assign best_d    = (can_store && (span_q > best_q)) ? span_q : best_q;

  dir_range_mem #(
    .DEPTH (TABLE_DEPTH),
    .AW    (AW),
    .DW    (2 * COORD_BITS)
  ) u_mem (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (count_q[AW-1:0]),
    .wr_data_i ({end_q, start_q}),
    .rd_en_i   (issue),
    .rd_addr_i (idx_q[AW-1:0]),
    .rd_data_o (rd_data)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      start_q  <= '0;
      end_q    <= '0;
      span_q   <= '0;
      bad_q    <= 1'b0;
      idx_q    <= '0;
      cmp_q    <= 1'b0;
      hit_q    <= 1'b0;
      count_q  <= '0;
      best_q   <= BW'(1);
      ovalid_q <= 1'b0;
      oacc_q   <= 1'b0;
      ofull_q  <= 1'b0;
      obest_q  <= BW'(1);
    end else begin
      // a new result in the decide step takes priority over the drain
      if (ovalid_q && m_axis_tready_i && !done_fire) begin
        ovalid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (s_axis_tvalid_i) begin
            start_q <= in_start;
            end_q   <= in_end;
            span_q  <= {1'b0, in_end} - {1'b0, in_start} + BW'(2);
            bad_q   <= (in_start > in_end);
            idx_q   <= '0;
            cmp_q   <= 1'b0;
            hit_q   <= 1'b0;
            state_q <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          cmp_q <= issue;
          idx_q <= idx_q + CW'(issue);
          if (hit_now) begin
            hit_q <= 1'b1;
          end
          if (!issue && !cmp_q) begin
            state_q <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (out_free) begin
            ovalid_q <= 1'b1;
            oacc_q   <= can_store;
            ofull_q  <= clean && is_full;
            obest_q  <= best_d;
            best_q   <= best_d;
            if (can_store) begin
              count_q <= count_q + CW'(1);
            end
            state_q <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign m_axis_tvalid_o = ovalid_q;
  assign m_axis_tdata_o  = OUT_W'({obest_q, ofull_q, oacc_q});

  // table never grows past its depth
  `DIR_ASSERT(a_count_bound, clk_i, rst_ni, count_q <= CW'(TABLE_DEPTH))
  // a stored range and a dropped-for-space flag never come together
  `DIR_ASSERT(a_flags_excl, clk_i, rst_ni, !(ovalid_q && oacc_q && ofull_q))
  // a write grows the fill count by exactly one
  `DIR_ASSERT_IMP(a_count_step, clk_i, rst_ni, wr_en, count_q == $past(count_q) + CW'(1))
  // the running best never falls
  `DIR_ASSERT_IMP(a_best_mono, clk_i, rst_ni, 1'b1, best_q >= $past(best_q))
endmodule
`default_nettype wire

// ===== verif/testbench.sv =====
// Testbench for disjoint_interval_reserve: directed and random range requests on the
// input stream, each result checked against a shadow copy of the reservation table.
// Depends on dir_pkg and the disjoint_interval_reserve RTL.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned DEPTH        = dir_pkg::DEF_TABLE_DEPTH;
  localparam int unsigned CB           = dir_pkg::DEF_COORD_BITS;
  localparam int unsigned IN_W         = ((2 * CB) + 7) / 8 * 8;
  localparam int unsigned OUT_W        = ((CB + 3) + 7) / 8 * 8;
  localparam int unsigned RANDOM_ITEMS = 1200;
  localparam int unsigned IDLE_LIMIT   = 5000;
  localparam int unsigned HOLD_AT      = 200;
  localparam int unsigned HOLD_CYCLES  = 600;
  localparam int unsigned DRAIN_CYCLES = DEPTH + 16;
  // random fresh ranges live in 8M-wide slots 1..255 of the low half
  localparam int unsigned SLOT_SHIFT   = 23;
  localparam int unsigned SLOT_COUNT   = 256;
  localparam longint      COORD_MAX    = (longint'(1) << CB) - 1;

  typedef logic [CB-1:0] coord_t;
  typedef logic [CB:0]   best_t;
  typedef struct { coord_t lo; coord_t hi; } span_t;
  typedef struct { logic accepted; logic full; best_t best; } verdict_t;

  typedef enum int { PICK_FRESH, PICK_OVERLAP, PICK_INVERTED, PICK_NOISE } pick_e;
  typedef enum int { HIT_AT_END, HIT_AT_START, HIT_INSIDE, HIT_COVER, HIT_EXACT } hit_e;

  logic             clk_i    = 1'b0;
  logic             rst_ni   = 1'b0;
  logic             s_tvalid = 1'b0;
  logic             s_tready;
  logic [IN_W-1:0]  s_tdata  = '0;
  logic             m_tvalid;
  logic             m_tready = 1'b0;
  logic [OUT_W-1:0] m_tdata;

  disjoint_interval_reserve uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_tvalid),
    .s_axis_tready_o(s_tready),
    // range_start, range_end
    .s_axis_tdata_i (s_tdata),
    .m_axis_tvalid_o(m_tvalid),
    .m_axis_tready_i(m_tready),
    // accepted, table_full, best_value, zero pad
    .m_axis_tdata_o (m_tdata)
  );

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------- shadow table
  coord_t      shadow_lo [DEPTH];
  coord_t      shadow_hi [DEPTH];
  int unsigned shadow_count = 0;
  best_t       shadow_best  = best_t'(1);

  function automatic verdict_t reserve_predict(coord_t lo, coord_t hi);
    verdict_t v;
    logic     clash;
    best_t    span;
    v.accepted = 1'b0;
    v.full     = 1'b0;
    clash      = 1'b0;
    // shared endpoints count as overlap
    for (int i = 0; i < shadow_count; i++)
      if (lo <= shadow_hi[i] && hi >= shadow_lo[i]) clash = 1'b1;
    if (lo <= hi && !clash) begin
      if (shadow_count >= DEPTH) begin
        v.full = 1'b1;
      end else begin
        span = {1'b0, hi} - {1'b0, lo} + best_t'(2);
        shadow_lo[shadow_count] = lo;
        shadow_hi[shadow_count] = hi;
        shadow_count++;
        if (span > shadow_best) shadow_best = span;
        v.accepted = 1'b1;
      end
    end
    v.best = shadow_best;
    return v;
  endfunction

  // ---------------------------------------------------------------- stimulus plan
  span_t request_q[$];
  span_t planned_spans[$];  // ranges meant to be stored, targets for overlap items
  bit    slot_taken [SLOT_COUNT];

  task automatic queue_span(longint lo, longint hi, bit stored);
    span_t s;
    s.lo = coord_t'(lo);
    s.hi = coord_t'(hi);
    request_q.push_back(s);
    if (stored) planned_spans.push_back(s);
  endtask

  task automatic plan_fresh();
    int unsigned slot;
    longint      lo;
    longint      len;
    slot = $urandom_range(SLOT_COUNT - 1, 1);
    for (int tries = 0; tries < 8 && slot_taken[slot]; tries++)
      slot = $urandom_range(SLOT_COUNT - 1, 1);
    slot_taken[slot] = 1'b1;
    len = ($urandom_range(3) == 0) ? $urandom_range(32'h3F_FFFF) : $urandom_range(255);
    lo  = (longint'(slot) << SLOT_SHIFT) + $urandom_range(32'h3F_FFFF, 1);
    queue_span(lo, lo + len, 1'b1);
  endtask

  // a range that touches or overlaps one of the planned ranges
  task automatic plan_overlap();
    span_t  r;
    longint a, b, lo, hi;
    r  = planned_spans[$urandom_range(planned_spans.size() - 1)];
    a  = r.lo;
    b  = r.hi;
    lo = a;
    hi = b;
    case (hit_e'($urandom_range(HIT_EXACT)))
      HIT_AT_END:   begin lo = b; hi = b + $urandom_range(4095); end
      HIT_AT_START: begin lo = a - $urandom_range(4095); hi = a; end
      HIT_INSIDE: begin
        lo = a + $urandom_range(32'(b - a));
        hi = lo + $urandom_range(32'(b - lo));
      end
      HIT_COVER: begin lo = a - $urandom_range(65535); hi = b + $urandom_range(65535); end
      default: ;
    endcase
    if (lo < 0) lo = 0;
    if (hi > COORD_MAX) hi = COORD_MAX;
    queue_span(lo, hi, 1'b0);
  endtask

  // ---------------------------------------------------------------- idling phases
  int unsigned taken_count = 0;
  int unsigned send_gap_pct;
  int unsigned recv_stall_pct;

  always_comb begin
    send_gap_pct   = 0;
    recv_stall_pct = 0;
    if (taken_count >= 920) begin
      send_gap_pct   = 27;
      recv_stall_pct = 27;
    end else if (taken_count >= 620) begin
      recv_stall_pct = 83;
    end else if (taken_count >= 320) begin
      send_gap_pct = 83;
    end
  end

  // ---------------------------------------------------------------- driver
  bit s_fired = 1'b0;  // set at the rising edge, read at the falling edge

  always @(negedge clk_i) begin
    span_t next;
    if (rst_ni && (!s_tvalid || s_fired)) begin
      if (request_q.size() != 0 && $urandom_range(99) >= send_gap_pct) begin
        next = request_q.pop_front();
        s_tvalid <= 1'b1;
        s_tdata  <= IN_W'({next.hi, next.lo});
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // receiver: random stalls, plus one long hold-off so the block backs up
  int unsigned hold_left = 0;
  bit          hold_done = 1'b0;

  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (hold_left != 0) begin
        hold_left <= hold_left - 1;
        m_tready  <= 1'b0;
      end else if (!hold_done && taken_count >= HOLD_AT) begin
        hold_left <= HOLD_CYCLES;
        hold_done <= 1'b1;
        m_tready  <= 1'b0;
      end else begin
        m_tready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // ---------------------------------------------------------------- monitor
  verdict_t    verdict_q[$];
  int unsigned result_count = 0;
  int unsigned mismatches   = 0;

  task automatic report_mismatch(string field, logic [63:0] got, logic [63:0] want);
    $display("mismatch: %s at result %0d: got %0h, want %0h", field, result_count, got, want);
    mismatches++;
  endtask

  always @(posedge clk_i) begin
    verdict_t want;
    s_fired = 1'b0;
    if (rst_ni) begin
      if (m_tvalid && m_tready) begin
        if (verdict_q.size() == 0) begin
          report_mismatch("result with nothing pending", 64'(m_tdata), 64'd0);
        end else begin
          want = verdict_q.pop_front();
          if (m_tdata[0] !== want.accepted)
            report_mismatch("accepted", 64'(m_tdata[0]), 64'(want.accepted));
          if (m_tdata[1] !== want.full)
            report_mismatch("table_full", 64'(m_tdata[1]), 64'(want.full));
          if (m_tdata[CB+2:2] !== want.best)
            report_mismatch("best_value", 64'(m_tdata[CB+2:2]), 64'(want.best));
          if (m_tdata[OUT_W-1:CB+3] !== '0)
            report_mismatch("pad", 64'(m_tdata[OUT_W-1:CB+3]), 64'd0);
        end
        result_count++;
      end
      if (s_tvalid && s_tready) begin
        verdict_q.push_back(reserve_predict(s_tdata[CB-1:0], s_tdata[2*CB-1:CB]));
        taken_count++;
        s_fired = 1'b1;
      end
    end
  end

  // watchdog: too long with no item moving on either side
  int unsigned stuck_cycles = 0;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) stuck_cycles <= 0;
      else stuck_cycles <= stuck_cycles + 1;
      if (stuck_cycles == IDLE_LIMIT) begin
        $display("testbench: FAIL");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------- sequence
  initial begin
    pick_e       pick;
    int unsigned roll;
    longint      lo;
    longint      hi;

    // directed: extremes, inverted ranges, touching endpoints, containment
    queue_span(0, 0, 1'b1);                               // zero-width at the bottom
    queue_span(COORD_MAX, COORD_MAX, 1'b1);               // zero-width at the top
    queue_span(0, COORD_MAX, 1'b0);                       // full span, overlaps both
    queue_span(5, 4, 1'b0);                               // inverted
    queue_span(COORD_MAX, 0, 1'b0);                       // inverted, widest
    queue_span(100, 200, 1'b1);
    queue_span(200, 300, 1'b0);                           // start on a stored end
    queue_span(50, 100, 1'b0);                            // end on a stored start
    queue_span(150, 160, 1'b0);                           // inside
    queue_span(99, 201, 1'b0);                            // covering
    queue_span(201, 300, 1'b1);                           // adjacent, no shared point
    queue_span(1, 99, 1'b1);
    queue_span(64'h8000_0000, COORD_MAX - 1, 1'b1);       // wide: large best
    queue_span(64'h7FFF_FFFF, 64'h8000_0000, 1'b0);       // touches the wide one
    queue_span(COORD_MAX - 1, COORD_MAX, 1'b0);
    queue_span(64'h5555_5555, 64'hAAAA_AAAA, 1'b0);
    queue_span(64'hAAAA_AAAA, 64'h5555_5555, 1'b0);       // inverted
    queue_span(302, 302, 1'b1);
    queue_span(301, 301, 1'b1);                           // single point between two

    // random: mostly hits on planned ranges, a trickle of fresh ones so the
    // table fills partway through and the full case shows up later
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      roll = $urandom_range(99);
      if (roll < 9)       pick = PICK_FRESH;
      else if (roll < 72) pick = PICK_OVERLAP;
      else if (roll < 86) pick = PICK_INVERTED;
      else                pick = PICK_NOISE;
      case (pick)
        PICK_FRESH:   plan_fresh();
        PICK_OVERLAP: plan_overlap();
        PICK_INVERTED: begin
          lo = $urandom_range(32'hFFFF_FFFF, 1);
          hi = ($urandom_range(1) != 0) ? lo - 1 : $urandom_range(32'(lo - 1));
          queue_span(lo, hi, 1'b0);
        end
        default: begin
          lo = $urandom();
          hi = $urandom();
          // well-formed noise reaches into the wide stored range
          if (lo <= hi) hi = hi | 64'h8000_0000;
          queue_span(lo, hi, 1'b0);
        end
      endcase
    end

    repeat (5) @(negedge clk_i);
    rst_ni <= 1'b1;

    while (request_q.size() != 0 || s_tvalid || verdict_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (mismatches == 0 && verdict_q.size() == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+src
src/dir_pkg.sv
src/dir_range_mem.sv
src/disjoint_interval_reserve.sv
verif/testbench.sv
